### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CBB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbb_pkg.sv
// types, constants and occupancy function of the circular byte buffer
package cbb_pkg;

    localparam int DEPTH       = 1024;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int MAX_PEEK    = 64;
    localparam int PEEK_CNT_W  = $clog2(MAX_PEEK + 1);
    localparam int BYTE_W      = 8;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_PEEK   = 2'd2,
        OP_POP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DATA  = 2'd1,
        ST_NO_ROOM  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [BYTE_W-1:0]  data;
        logic [PTR_W-1:0]   offset;
        logic [PTR_W-1:0]   length;
    } t_in_item;

    typedef struct packed {
        logic [PTR_W-1:0] used;
        logic [PTR_W-1:0] free;
        logic [PTR_W-1:0] room;
    } t_occ;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  data_res;
        logic               last;
        logic [PTR_W-1:0]   used_bytes;
        logic [PTR_W-1:0]   free_bytes;
        logic [PTR_W-1:0]   contiguous_room;
    } t_out_item;

    function automatic t_occ calc_occ(input logic [PTR_W-1:0] wp, input logic [PTR_W-1:0] rp);
        t_occ       occ;
        logic [PTR_W:0] run;
        occ.used = wp - rp;
        occ.free = PTR_W'(DEPTH - 1) - occ.used;
        if (rp <= wp) begin
            run = (PTR_W + 1)'(DEPTH) - {1'b0, wp};
            if (rp == '0) begin
                run = run - 1'b1;
            end
        end else begin
            run = {1'b0, rp - wp - 1'b1};
        end
        occ.room = run[PTR_W-1:0];
        return occ;
    endfunction

endpackage

### hw/rtl/cbb_ram.sv
// simple dual-port ram with registered read data held between reads
module cbb_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [(1 << ADDR_W)];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/circular_byte_buffer.sv
// top level of the circular byte buffer
// Input channel i_in_valid/o_in_ready carries one t_in_item per transaction:
// store a byte at write pointer plus offset, commit a length, peek a length
// of bytes from the read pointer, or pop a length. Output channel
// o_out_valid/i_out_ready carries t_out_item results; each holds status,
// the peeked byte and the occupancy after the operation, and last marks
// the final result of a transaction.
// Store, commit, pop and every refused or empty peek give one result in the
// cycle after acceptance; the next transaction is taken in that same cycle
// when the output register drains, so one transaction per cycle.
// A peek of N bytes reads the byte ram once per byte; its first byte passes
// through the ram read register and then the output register, and the rest follow
// one per cycle unless stalled, a rate set by the single ram read port.
// Reset clears both pointers and empties the output register; the byte ram
// is not cleared, so bytes never stored read back as unknown.
// When the receiver stalls the result is held in the output register and
// a peek pauses with the next byte held at the ram output; no input
// transaction is taken until the output register can be refilled.
`include "assert_macros.svh"

module circular_byte_buffer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cbb_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cbb_pkg::t_out_item o_out_item
);
    import cbb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_PEEK
    } t_state;

    t_state                r_state;
    logic [PTR_W-1:0]      r_wp;
    logic [PTR_W-1:0]      r_rp;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  r_rd_pend;
    logic [PTR_W-1:0]      r_raddr;
    logic [PEEK_CNT_W-1:0] r_issue;
    logic [PEEK_CNT_W-1:0] r_left;

    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;
    t_out_item         n_res;
    t_occ              occ_cur;
    t_occ              occ_nxt;
    logic              out_free;
    logic              in_acc;
    logic              store_ok;
    logic              commit_ok;
    logic              pop_ok;
    logic              peek_long;
    logic              peek_short;
    logic              peek_empty;
    logic              peek_go;
    logic              byte_load;
    logic              rd_en;
    logic              wr_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] rd_data;

    assign occ_cur    = calc_occ(r_wp, r_rp);
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign store_ok   = i_in_item.offset < occ_cur.free;
    assign commit_ok  = i_in_item.length <= occ_cur.free;
    assign pop_ok     = i_in_item.length <= occ_cur.used;
    assign peek_long  = i_in_item.length > PTR_W'(MAX_PEEK);
    assign peek_short = i_in_item.length > occ_cur.used;
    assign peek_empty = i_in_item.length == '0;
    assign peek_go    = in_acc && (i_in_item.operation == OP_PEEK)
                        && !peek_long && !peek_short && !peek_empty;

    assign wr_en   = in_acc && (i_in_item.operation == OP_STORE) && store_ok;
    assign wr_addr = r_wp + i_in_item.offset;

    assign byte_load = (r_state == S_PEEK) && r_rd_pend && out_free;
    assign rd_en     = peek_go
                       || ((r_state == S_PEEK) && (r_issue != '0) && (!r_rd_pend || byte_load));
    assign rd_addr   = (r_state == S_IDLE) ? r_rp : r_raddr;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_res.status = ST_OK;
        unique case (i_in_item.operation)
            OP_STORE: begin
                if (!store_ok) begin
                    n_res.status = ST_NO_ROOM;
                end
            end
            OP_COMMIT: begin
                if (commit_ok) begin
                    n_wp = r_wp + i_in_item.length;
                end else begin
                    n_res.status = ST_NO_ROOM;
                end
            end
            OP_PEEK: begin
                priority if (peek_long) begin
                    n_res.status = ST_TOO_LONG;
                end else if (peek_short) begin
                    n_res.status = ST_NO_DATA;
                end else begin
                    n_res.status = ST_OK;
                end
            end
            OP_POP: begin
                if (pop_ok) begin
                    n_rp = r_rp + i_in_item.length;
                end else begin
                    n_res.status = ST_NO_DATA;
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase
        occ_nxt               = calc_occ(n_wp, n_rp);
        n_res.data_res        = '0;
        n_res.last            = 1'b1;
        n_res.used_bytes      = occ_nxt.used;
        n_res.free_bytes      = occ_nxt.free;
        n_res.contiguous_room = occ_nxt.room;
    end

    cbb_ram #(
        .WIDTH  (BYTE_W),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in_item.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_issue     <= '0;
            r_left      <= '0;
        end else begin
            if (in_acc) begin
                r_out_valid <= !peek_go;
                r_out       <= n_res;
                r_wp        <= n_wp;
                r_rp        <= n_rp;
            end else if (byte_load) begin
                r_out_valid           <= 1'b1;
                r_out.status          <= ST_OK;
                r_out.data_res        <= rd_data;
                r_out.last            <= (r_left == PEEK_CNT_W'(1));
                r_out.used_bytes      <= occ_cur.used;
                r_out.free_bytes      <= occ_cur.free;
                r_out.contiguous_room <= occ_cur.room;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (rd_en) begin
                r_rd_pend <= 1'b1;
            end else if (byte_load) begin
                r_rd_pend <= 1'b0;
            end

            if (peek_go) begin
                r_state <= S_PEEK;
                r_raddr <= r_rp + 1'b1;
                r_issue <= i_in_item.length[PEEK_CNT_W-1:0] - 1'b1;
                r_left  <= i_in_item.length[PEEK_CNT_W-1:0];
            end else if (r_state == S_PEEK) begin
                if (rd_en) begin
                    r_raddr <= r_raddr + 1'b1;
                    r_issue <= r_issue - 1'b1;
                end
                if (byte_load) begin
                    r_left <= r_left - 1'b1;
                    if (r_left == PEEK_CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `CBB_ASSERT_IMPL(a_mid_result_in_peek, i_clk, i_rst_n, r_out_valid && !r_out.last, r_state == S_PEEK, "non-final result outside a peek")
    `CBB_ASSERT_NEXT(a_ptr_hold_in_peek, i_clk, i_rst_n, r_state == S_PEEK, $stable(r_wp) && $stable(r_rp), "pointer moved during a peek")
    `CBB_ASSERT_IMPL(a_pend_in_peek, i_clk, i_rst_n, r_rd_pend, (r_state == S_PEEK) && (r_left != '0), "ram read pending outside a peek")

endmodule
